/* rtl/rmj_pkg.sv */
package rmj_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int GUARD_BITS = 8;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SQ_W       = PROD_W + 2 * GUARD_BITS;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int ROOT_HI_W  = ROOT_W - DATA_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int Q_W        = DATA_W;
    localparam int DEN_W      = PROD_W + ROOT_W;
    localparam int MAG_PROD_W = DATA_W + PROD_W;
    localparam int NUM_W      = MAG_PROD_W + FRAC_BITS + GUARD_BITS;
    localparam int CFG_W      = 31;
    localparam int LIMIT_W    = CFG_W + FRAC_BITS;
    localparam int N_OUT      = 6;
    localparam int IN_DATA_W  = 4 * DATA_W;
    localparam int OUT_DATA_W = N_OUT * DATA_W;
    localparam int FRONT_LAT  = 4;
    localparam int DIV_LAT    = Q_W + 1;
    localparam int ADDR_W     = 3;
    localparam int APB_W      = 32;

    localparam int                CFG_MIN_RANGE_IDX = 0;
    localparam logic [CFG_W-1:0]  MIN_RANGE_RESET   = CFG_W'(7);

    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [PROD_W-1:0] s2;
        logic [DATA_W-1:0] ax;
        logic [DATA_W-1:0] ay;
        logic [PROD_W-1:0] dmag;
        logic              px_neg;
        logic              py_neg;
        logic              d_neg;
        logic              too_close;
    } t_front;

    typedef struct packed {
        logic px_neg;
        logic py_neg;
        logic d_neg;
        logic too_close;
    } t_side;

    // clamp a truncated quotient magnitude to the signed output range
    function automatic logic [DATA_W-1:0] saturate(input logic [Q_W-1:0] q,
                                                   input logic ovf,
                                                   input logic neg);
        logic [DATA_W-1:0] res;
        if (neg) begin
            if (ovf || (q > MIN_NEG)) res = MIN_NEG;
            else                      res = DATA_W'(-q);
        end else begin
            if (ovf || (q > MAX_POS)) res = MAX_POS;
            else                      res = q;
        end
        return res;
    endfunction

endpackage

/* rtl/rmj_front.sv */
module rmj_front import rmj_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic [CFG_W-1:0]     i_min_range,
    output logic                 o_valid,
    output t_front               o_front
);

    logic [FRONT_LAT-1:0]       r_vld;
    // F1
    logic signed [DATA_W-1:0]   r_px, r_py, r_vx, r_vy;
    logic [DATA_W-1:0]          r_ax1, r_ay1;
    logic                       r_pxn1, r_pyn1;
    // F2
    logic [PROD_W-1:0]          r_axx, r_ayy;
    logic signed [PROD_W-1:0]   r_vxpy, r_vypx;
    logic [DATA_W-1:0]          r_ax2, r_ay2;
    logic                       r_pxn2, r_pyn2;
    // F3
    logic [PROD_W-1:0]          r_s2;
    logic signed [PROD_W:0]     r_diff;
    logic [DATA_W-1:0]          r_ax3, r_ay3;
    logic                       r_pxn3, r_pyn3;
    // F4
    t_front                     r_out;

    logic signed [DATA_W-1:0]   n_px, n_py;
    logic [PROD_W-1:0]          n_limit;

    assign n_px    = i_data[DATA_W-1:0];
    assign n_py    = i_data[2*DATA_W-1:DATA_W];
    assign n_limit = PROD_W'({i_min_range, FRAC_BITS'(0)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[FRONT_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_vx   <= i_data[3*DATA_W-1:2*DATA_W];
            r_vy   <= i_data[4*DATA_W-1:3*DATA_W];
            r_ax1  <= n_px[DATA_W-1] ? DATA_W'(-n_px) : DATA_W'(n_px);
            r_ay1  <= n_py[DATA_W-1] ? DATA_W'(-n_py) : DATA_W'(n_py);
            r_pxn1 <= n_px[DATA_W-1];
            r_pyn1 <= n_py[DATA_W-1];

            r_axx  <= PROD_W'(r_ax1) * PROD_W'(r_ax1);
            r_ayy  <= PROD_W'(r_ay1) * PROD_W'(r_ay1);
            r_vxpy <= PROD_W'(r_vx) * PROD_W'(r_py);
            r_vypx <= PROD_W'(r_vy) * PROD_W'(r_px);
            r_ax2  <= r_ax1;
            r_ay2  <= r_ay1;
            r_pxn2 <= r_pxn1;
            r_pyn2 <= r_pyn1;

            r_s2   <= r_axx + r_ayy;
            r_diff <= {r_vxpy[PROD_W-1], r_vxpy} - {r_vypx[PROD_W-1], r_vypx};
            r_ax3  <= r_ax2;
            r_ay3  <= r_ay2;
            r_pxn3 <= r_pxn2;
            r_pyn3 <= r_pyn2;

            r_out.s2        <= r_s2;
            r_out.ax        <= r_ax3;
            r_out.ay        <= r_ay3;
            r_out.dmag      <= r_diff[PROD_W] ? PROD_W'(-r_diff) : PROD_W'(r_diff);
            r_out.px_neg    <= r_pxn3;
            r_out.py_neg    <= r_pyn3;
            r_out.d_neg     <= r_diff[PROD_W];
            r_out.too_close <= (r_s2 == '0) || (r_s2 < n_limit);
        end
    end

    assign o_valid = r_vld[FRONT_LAT-1];
    assign o_front = r_out;

endmodule

/* rtl/rmj_sqrt.sv */
module rmj_sqrt import rmj_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_front            i_front,
    output logic              o_valid,
    output t_front            o_front,
    output logic [ROOT_W-1:0] o_root
);

    // one root bit per stage, restoring digit recurrence on s2 << 2*GUARD
    logic              r_vld  [0:ROOT_W];
    t_front            r_pay  [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [SQ_W-1:0]   r_x    [0:ROOT_W-1];

    logic [REM_W-1:0]  n_rem2  [0:ROOT_W-1];
    logic [REM_W-1:0]  n_trial [0:ROOT_W-1];
    logic              n_ge    [0:ROOT_W-1];
    logic [REM_W-1:0]  n_rem   [0:ROOT_W-1];

    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            n_rem2[k]  = {r_rem[k][REM_W-3:0], r_x[k][SQ_W-1 -: 2]};
            n_trial[k] = {r_root[k], 2'b01};
            n_ge[k]    = n_rem2[k] >= n_trial[k];
            n_rem[k]   = n_ge[k] ? (n_rem2[k] - n_trial[k]) : n_rem2[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ROOT_W; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < ROOT_W; k++) r_vld[k+1] <= r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay[0]  <= i_front;
            r_root[0] <= '0;
            r_rem[0]  <= '0;
            r_x[0]    <= {i_front.s2, (2*GUARD_BITS)'(0)};
            for (int k = 0; k < ROOT_W; k++) begin
                r_pay[k+1]  <= r_pay[k];
                r_root[k+1] <= {r_root[k][ROOT_W-2:0], n_ge[k]};
            end
            for (int k = 0; k < ROOT_W-1; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_x[k+1]   <= r_x[k] << 2;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W];
    assign o_front = r_pay[ROOT_W];
    assign o_root  = r_root[ROOT_W];

endmodule

/* rtl/rmj_div.sv */
module rmj_div import rmj_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo,
    output logic             o_ovf
);

    // overflow when quotient needs more than Q_W bits; else one bit per stage
    logic [DEN_W-1:0] r_rem [0:Q_W-1];
    logic [Q_W-1:0]   r_low [0:Q_W-1];
    logic [DEN_W-1:0] r_den [0:Q_W-1];
    logic [Q_W-1:0]   r_quo [0:Q_W];
    logic             r_ovf [0:Q_W];

    logic [DEN_W:0]   n_trial [0:Q_W-1];
    logic             n_ge    [0:Q_W-1];
    logic [DEN_W-1:0] n_rem   [0:Q_W-1];
    logic [DEN_W-1:0] n_hi;

    assign n_hi = DEN_W'(i_num[NUM_W-1:Q_W]);

    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            n_trial[k] = {r_rem[k], r_low[k][Q_W-1]};
            n_ge[k]    = n_trial[k] >= {1'b0, r_den[k]};
            n_rem[k]   = n_ge[k] ? DEN_W'(n_trial[k] - {1'b0, r_den[k]})
                                 : n_trial[k][DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= n_hi >= i_den;
            r_rem[0] <= n_hi;
            r_low[0] <= i_num[Q_W-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            for (int k = 0; k < Q_W; k++) begin
                r_ovf[k+1] <= r_ovf[k];
                r_quo[k+1] <= {r_quo[k][Q_W-2:0], n_ge[k]};
            end
            for (int k = 0; k < Q_W-1; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_low[k+1] <= r_low[k] << 1;
                r_den[k+1] <= r_den[k];
            end
        end
    end

    assign o_quo = r_quo[Q_W];
    assign o_ovf = r_ovf[Q_W];

endmodule

/* rtl/radar_measurement_jacobian.sv */
// Radar measurement Jacobian: range, bearing and range-rate partials of one
// tracked state (px, py, vx, vy, signed Q16.16).
// Input stream: one state per transfer on i_s_*. Output stream: six Jacobian
// entries on o_m_tdata and the too-close flag on o_m_tuser, one transfer per
// state, in order. Entries round toward zero and saturate to Q16.16.
// Config: APB register 0 (byte address 0) holds the minimum squared range;
// below it (or at zero range) every entry is zero and the flag is set.
// Write it only while no states are in flight.
// Throughput: one state per cycle while not stalled. The path from the input
// transfer to the result on the output port runs through the front multiplier
// stages, the 41-stage square root and the 33-stage dividers.
// Stall: the whole pipeline advances together; a two-entry output buffer
// lets it keep accepting while one result waits, and o_s_tready drops only
// when both entries hold unread results. Nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and output buffer
// and restores the threshold to 7 (about 0.0001).
module radar_measurement_jacobian import rmj_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // pos_x, pos_y, vel_x, vel_y from bit 0 up
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // range_by_px, range_by_py, bearing_by_px, bearing_by_py,
    // rate_by_px, rate_by_py from bit 0 up
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // too_close
    output logic [0:0]            o_m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]      prdata,
    output logic                  pready
);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_min_range;
    logic             cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = paddr[ADDR_W-1:2] == (ADDR_W-2)'(CFG_MIN_RANGE_IDX);
    assign prdata  = cfg_hit ? APB_W'(r_min_range) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range <= MIN_RANGE_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_min_range <= pwdata[CFG_W-1:0];
        end
    end

    // ---------------- pipeline enable ----------------
    // Single enable for every stage; blocked only when the output buffer is full.
    logic [1:0] r_cnt;
    logic       pipe_en;

    assign pipe_en    = r_cnt != 2'd2;
    assign o_s_tready = pipe_en;

    // ---------------- front: magnitudes, squares, cross term ----------------
    logic   fr_valid;
    t_front fr_data;

    rmj_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_valid     (i_s_tvalid),
        .i_data      (i_s_tdata),
        .i_min_range (r_min_range),
        .o_valid     (fr_valid),
        .o_front     (fr_data)
    );

    // ---------------- range: R = isqrt(s2 << 2*GUARD) ----------------
    logic              sq_valid;
    t_front            sq_data;
    logic [ROOT_W-1:0] sq_root;

    rmj_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (fr_valid),
        .i_front (fr_data),
        .o_valid (sq_valid),
        .o_front (sq_data),
        .o_root  (sq_root)
    );

    // ---------------- M1: partial products of 32-bit slices ----------------
    logic                 r_m1_vld;
    t_front               r_m1_front;
    logic [ROOT_W-1:0]    r_m1_root;
    logic [PROD_W-1:0]    r_pa_l, r_pa_h, r_pb_l, r_pb_h;   // ay*dmag, ax*dmag halves
    logic [PROD_W-1:0]    r_s_ll, r_s_hl;                   // s2 halves * R low
    logic [DATA_W+ROOT_HI_W-1:0] r_s_lh, r_s_hh;            // s2 halves * R high

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (pipe_en) begin
            r_m1_vld <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_m1_front <= sq_data;
            r_m1_root  <= sq_root;
            r_pa_l <= PROD_W'(sq_data.ay) * PROD_W'(sq_data.dmag[DATA_W-1:0]);
            r_pa_h <= PROD_W'(sq_data.ay) * PROD_W'(sq_data.dmag[PROD_W-1:DATA_W]);
            r_pb_l <= PROD_W'(sq_data.ax) * PROD_W'(sq_data.dmag[DATA_W-1:0]);
            r_pb_h <= PROD_W'(sq_data.ax) * PROD_W'(sq_data.dmag[PROD_W-1:DATA_W]);
            r_s_ll <= PROD_W'(sq_data.s2[DATA_W-1:0]) * PROD_W'(sq_root[DATA_W-1:0]);
            r_s_hl <= PROD_W'(sq_data.s2[PROD_W-1:DATA_W]) * PROD_W'(sq_root[DATA_W-1:0]);
            r_s_lh <= (DATA_W+ROOT_HI_W)'(sq_data.s2[DATA_W-1:0])
                    * (DATA_W+ROOT_HI_W)'(sq_root[ROOT_W-1:DATA_W]);
            r_s_hh <= (DATA_W+ROOT_HI_W)'(sq_data.s2[PROD_W-1:DATA_W])
                    * (DATA_W+ROOT_HI_W)'(sq_root[ROOT_W-1:DATA_W]);
        end
    end

    // ---------------- M2: assemble dividends and divisors ----------------
    logic             r_m2_vld;
    t_side            r_m2_side;
    logic [NUM_W-1:0] r_num [0:N_OUT-1];
    logic [DEN_W-1:0] r_den [0:N_OUT-1];

    logic [MAG_PROD_W-1:0] n_pa, n_pb;
    logic [DEN_W-1:0]      n_s2r;

    assign n_pa  = MAG_PROD_W'(r_pa_l) + (MAG_PROD_W'(r_pa_h) << DATA_W);
    assign n_pb  = MAG_PROD_W'(r_pb_l) + (MAG_PROD_W'(r_pb_h) << DATA_W);
    assign n_s2r = DEN_W'(r_s_ll) + (DEN_W'(r_s_hl) << DATA_W)
                 + (DEN_W'(r_s_lh) << DATA_W) + (DEN_W'(r_s_hh) << PROD_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (pipe_en) begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_m2_side.px_neg    <= r_m1_front.px_neg;
            r_m2_side.py_neg    <= r_m1_front.py_neg;
            r_m2_side.d_neg     <= r_m1_front.d_neg;
            r_m2_side.too_close <= r_m1_front.too_close;
            // px/r, py/r
            r_num[0] <= NUM_W'(r_m1_front.ax) << (FRAC_BITS + GUARD_BITS);
            r_den[0] <= DEN_W'(r_m1_root);
            r_num[1] <= NUM_W'(r_m1_front.ay) << (FRAC_BITS + GUARD_BITS);
            r_den[1] <= DEN_W'(r_m1_root);
            // py/r^2, px/r^2
            r_num[2] <= NUM_W'(r_m1_front.ay) << (2 * FRAC_BITS);
            r_den[2] <= DEN_W'(r_m1_front.s2);
            r_num[3] <= NUM_W'(r_m1_front.ax) << (2 * FRAC_BITS);
            r_den[3] <= DEN_W'(r_m1_front.s2);
            // p*|D| / (s2 * R): nested floors collapse into one division
            r_num[4] <= NUM_W'(n_pa) << (FRAC_BITS + GUARD_BITS);
            r_den[4] <= n_s2r;
            r_num[5] <= NUM_W'(n_pb) << (FRAC_BITS + GUARD_BITS);
            r_den[5] <= n_s2r;
        end
    end

    // ---------------- dividers ----------------
    logic [Q_W-1:0] dv_quo [0:N_OUT-1];
    logic           dv_ovf [0:N_OUT-1];

    for (genvar g = 0; g < N_OUT; g++) begin : g_div
        rmj_div u_div (
            .i_clk (i_clk),
            .i_en  (pipe_en),
            .i_num (r_num[g]),
            .i_den (r_den[g]),
            .o_quo (dv_quo[g]),
            .o_ovf (dv_ovf[g])
        );
    end

    // sign and flag bits ride alongside the divider stages
    logic  r_dvld  [0:DIV_LAT-1];
    t_side r_dside [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) r_dvld[k] <= 1'b0;
        end else if (pipe_en) begin
            r_dvld[0] <= r_m2_vld;
            for (int k = 0; k < DIV_LAT-1; k++) r_dvld[k+1] <= r_dvld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_dside[0] <= r_m2_side;
            for (int k = 0; k < DIV_LAT-1; k++) r_dside[k+1] <= r_dside[k];
        end
    end

    // ---------------- sign, saturation, zero on too-close ----------------
    t_side                 fin_side;
    logic [N_OUT-1:0]      fin_neg;
    logic [OUT_DATA_W-1:0] n_data;

    assign fin_side   = r_dside[DIV_LAT-1];
    assign fin_neg[0] = fin_side.px_neg;
    assign fin_neg[1] = fin_side.py_neg;
    assign fin_neg[2] = !fin_side.py_neg;
    assign fin_neg[3] = fin_side.px_neg;
    assign fin_neg[4] = fin_side.py_neg ^ fin_side.d_neg;
    assign fin_neg[5] = !(fin_side.px_neg ^ fin_side.d_neg);

    always_comb begin
        for (int i = 0; i < N_OUT; i++) begin
            n_data[i*DATA_W +: DATA_W] = fin_side.too_close ? '0
                                       : saturate(dv_quo[i], dv_ovf[i], fin_neg[i]);
        end
    end

    // ---------------- two-entry output buffer ----------------
    logic                  r_head_user, r_tail_user;
    logic [OUT_DATA_W-1:0] r_head_data, r_tail_data;
    logic                  push, pop;
    logic [1:0]            n_cnt;

    assign push  = pipe_en && r_dvld[DIV_LAT-1];
    assign pop   = o_m_tvalid && i_m_tready;
    assign n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && (r_cnt == 2'd2)) begin
            r_head_data <= r_tail_data;
            r_head_user <= r_tail_user;
        end
        if (push) begin
            if ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop)) begin
                r_head_data <= n_data;
                r_head_user <= fin_side.too_close;
            end else begin
                r_tail_data <= n_data;
                r_tail_user <= fin_side.too_close;
            end
        end
    end

    assign o_m_tvalid   = r_cnt != 2'd0;
    assign o_m_tdata    = r_head_data;
    assign o_m_tuser[0] = r_head_user;

    // ---------------- checks ----------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("too-close result carries nonzero entries");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_dvld[DIV_LAT-1]))
        else $error("pipeline moved while stalled");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !push)
        else $error("push into full output buffer");

endmodule

/* verif/radar_measurement_jacobian_test.sv */
`timescale 1ns / 100ps

module radar_measurement_jacobian_test;
    import rmj_pkg::*;

    // one Jacobian result: six entries from bit 0 up, plus the too-close flag
    typedef struct {
        logic [OUT_DATA_W-1:0] entries;
        logic                  close;
    } jacobian_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // pos_x, pos_y, vel_x, vel_y from bit 0 up
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // range_by_px, range_by_py, bearing_by_px, bearing_by_py, rate_by_px, rate_by_py
    logic [OUT_DATA_W-1:0] o_m_tdata;
    // too_close
    logic [0:0]            o_m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [APB_W-1:0]      pwdata = '0;
    logic [APB_W-1:0]      prdata;
    logic                  pready;

    radar_measurement_jacobian dut (.*);

    always #1 i_clk = ~i_clk;

    // testbench copy of the threshold register
    logic [CFG_W-1:0]      min_range_sq = MIN_RANGE_RESET;

    logic [IN_DATA_W-1:0]  pending_states[$];
    jacobian_t             expected_jacobians[$];
    bit                    idling_on = 1'b1;
    int                    fail_count = 0;
    int                    states_sent = 0;
    int                    results_seen = 0;
    int                    close_seen = 0;
    int                    saturated_seen = 0;

    // long receiver hold-off, counted here
    logic                  hold_go = 1'b0;
    logic                  hold_done = 1'b0;
    int                    hold_left = 0;

    function automatic logic [DATA_W-1:0] clamp_entry(input logic [127:0] mag, input bit neg);
        if (neg) return (mag > 128'h8000_0000) ? MIN_NEG : DATA_W'(-mag[DATA_W-1:0]);
        return (mag > 128'h7FFF_FFFF) ? MAX_POS : mag[DATA_W-1:0];
    endfunction

    // expected Jacobian for one state under the current threshold
    function automatic jacobian_t jacobian_of(input logic [IN_DATA_W-1:0] st);
        logic signed [DATA_W-1:0] px, py, vx, vy;
        logic [127:0] ax, ay, s2, lim, x, t, q, dmag;
        logic signed [127:0] d;
        bit dneg;
        jacobian_t j;
        px = st[31:0]; py = st[63:32]; vx = st[95:64]; vy = st[127:96];
        ax = (px < 0) ? 128'(-64'(px)) : 128'(px);
        ay = (py < 0) ? 128'(-64'(py)) : 128'(py);
        s2 = ax * ax + ay * ay;
        lim = 128'(min_range_sq) << FRAC_BITS;
        j.entries = '0;
        j.close = 1'b1;
        if (s2 == 0 || s2 < lim) return j;
        j.close = 1'b0;
        // range with guard bits, truncated square root
        x = s2 << (2 * GUARD_BITS);
        q = 0;
        for (int b = 40; b >= 0; b--) begin
            t = q | (128'd1 << b);
            if (t * t <= x) q = t;
        end
        d = 128'(vx) * 128'(py) - 128'(vy) * 128'(px);
        dneg = d < 0;
        dmag = dneg ? 128'(-d) : 128'(d);
        j.entries[31:0]    = clamp_entry((ax << (FRAC_BITS + GUARD_BITS)) / q, px < 0);
        j.entries[63:32]   = clamp_entry((ay << (FRAC_BITS + GUARD_BITS)) / q, py < 0);
        j.entries[95:64]   = clamp_entry((ay << (2 * FRAC_BITS)) / s2, py > 0);
        j.entries[127:96]  = clamp_entry((ax << (2 * FRAC_BITS)) / s2, px < 0);
        j.entries[159:128] = clamp_entry(((ay * dmag) << (FRAC_BITS + GUARD_BITS)) / s2 / q,
                                         (py < 0) != dneg);
        j.entries[191:160] = clamp_entry(((ax * dmag) << (FRAC_BITS + GUARD_BITS)) / s2 / q,
                                         (px < 0) == dneg);
        return j;
    endfunction

    // driver: predict on each accepted transfer, then offer the next state
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_jacobians.push_back(jacobian_of(i_s_tdata));
                states_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_states.size() > 0) begin
                    i_s_tdata <= pending_states.pop_front();
                    i_s_tvalid <= 1'b1;
                    if (idling_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 7);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    int sink_gap = 0;
    always @(posedge i_clk) begin
        jacobian_t e;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (expected_jacobians.size() == 0) begin
                    $display("%0t: unexpected result %h / %b", $time, o_m_tdata, o_m_tuser);
                    fail_count++;
                end else begin
                    e = expected_jacobians.pop_front();
                    if (e.close) close_seen++;
                    for (int k = 0; k < N_OUT; k++) begin
                        if (e.entries[k*32 +: 32] inside {MAX_POS, MIN_NEG}) saturated_seen++;
                        if (o_m_tdata[k*32 +: 32] !== e.entries[k*32 +: 32]) begin
                            $display("%0t: entry %0d expected %h actual %h", $time, k,
                                     e.entries[k*32 +: 32], o_m_tdata[k*32 +: 32]);
                            fail_count++;
                        end
                    end
                    if (o_m_tuser[0] !== e.close) begin
                        $display("%0t: too_close expected %b actual %b", $time, e.close,
                                 o_m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if (sink_gap > 0) sink_gap--;
            else if (idling_on && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 7);
            i_m_tready <= (hold_left == 0) && (sink_gap == 0);
        end
    end

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
        // only the threshold register exists; the other word address is ignored
        if (addr == ADDR_W'(CFG_MIN_RANGE_IDX * 4)) min_range_sq = val[CFG_W-1:0];
        // read back the threshold
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b0; paddr <= ADDR_W'(CFG_MIN_RANGE_IDX * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== min_range_sq) begin
            $display("%0t: threshold readback expected %h actual %h", $time, min_range_sq,
                     prdata[CFG_W-1:0]);
            fail_count++;
        end
        psel <= 1'b0; penable <= 1'b0;
    endtask

    function automatic logic [IN_DATA_W-1:0] state_of(input logic [31:0] px, py, vx, vy);
        return {vy, vx, py, px};
    endfunction

    // random field: mostly scaled-down values, some full width
    function automatic logic [31:0] rand_field();
        logic [31:0] v;
        v = $urandom();
        if ($urandom_range(0, 3) != 0) v = $signed(v) >>> $urandom_range(0, 28);
        return v;
    endfunction

    // let everything drain, then cover the pipeline latency before a register write
    task automatic drain();
        while (pending_states.size() > 0 || i_s_tvalid || expected_jacobians.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic random_states(input int n);
        repeat (n) pending_states.push_back(state_of(rand_field(), rand_field(),
                                                     rand_field(), rand_field()));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset threshold (7), extremes, axes, boundary, saturation
        pending_states.push_back(state_of(0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_states.push_back(state_of(677, 0, 1, 1));
        pending_states.push_back(state_of(678, 0, 1, 1));
        pending_states.push_back(state_of(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 32'h8000_0000));
        pending_states.push_back(state_of(32'h8000_0000, 32'h8000_0000,
                                          32'h8000_0000, 32'h7FFF_FFFF));
        pending_states.push_back(state_of(32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000));
        pending_states.push_back(state_of(0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        pending_states.push_back(state_of(32'h0001_0000, 0, 0, 32'h0001_0000));
        pending_states.push_back(state_of(0, 32'hFFFF_0000, 32'h0001_0000, 0));
        pending_states.push_back(state_of(32'h0000_0400, 32'hFFFF_FC00,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_states.push_back(state_of(32'hFFFF_FD00, 32'h0000_0300,
                                          32'h8000_0000, 32'h7FFF_FFFF));
        pending_states.push_back(state_of(32'h0003_0000, 32'h0004_0000,
                                          32'hFFFE_0000, 32'h0005_0000));
        drain();

        // exact boundary: threshold limit equals a perfect square
        reg_write(ADDR_W'(0), 32'd16384);
        pending_states.push_back(state_of(32768, 0, 5, 7));
        pending_states.push_back(state_of(32767, 0, 5, 7));
        pending_states.push_back(state_of(0, 32'hFFFF_8000, 32'h8000_0000, 3));
        random_states(100);
        drain();

        // zero threshold: only the origin is too close
        reg_write(ADDR_W'(0), 32'd0);
        reg_write(ADDR_W'(4), 32'h1234_5678);
        pending_states.push_back(state_of(0, 0, 1, 1));
        pending_states.push_back(state_of(1, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_states.push_back(state_of(0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        random_states(150);
        // receiver holds off while the sender keeps offering
        @(posedge i_clk);
        hold_go <= 1'b1;
        drain();

        // maximum threshold: most states too close
        reg_write(ADDR_W'(0), 32'h7FFF_FFFF);
        random_states(100);
        drain();

        // random threshold, then reset value with no idling at the end
        reg_write(ADDR_W'(0), APB_W'({1'b0, $urandom()} >> $urandom_range(0, 31)));
        random_states(200);
        drain();
        reg_write(ADDR_W'(0), 32'(MIN_RANGE_RESET));
        random_states(100);
        drain();
        idling_on = 1'b0;
        random_states(150);
        drain();

        $display("Sent %0d states over six threshold settings; %0d results, %0d too close,",
                 states_sent, results_seen, close_seen);
        $display("%0d saturated entries, one long output stall.", saturated_seen);
        if (fail_count == 0) begin
            $display("radar_measurement_jacobian_test OK");
        end else begin
            $display("radar_measurement_jacobian_test NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("radar_measurement_jacobian_test NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
rtl/rmj_pkg.sv
rtl/rmj_front.sv
rtl/rmj_sqrt.sv
rtl/rmj_div.sv
rtl/radar_measurement_jacobian.sv
verif/radar_measurement_jacobian_test.sv
